[rtl/core/tlgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgc_pkg
// Shared types and codes of the track link graph cleaner.
// ----------------------------------------------------------------------------
package tlgc_pkg;

    localparam int LINK_W = 9;
    localparam int CFG_AW = 3;

    // table geometry, fixed by the 8-bit row and hit fields
    localparam int MAX_ROWS         = 256;
    localparam int MAX_HITS_PER_ROW = 256;

    // register byte addresses
    localparam logic [CFG_AW-1:0] REG_NROWS = 3'd0;
    localparam logic [CFG_AW-1:0] REG_STEP  = 3'd4;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,      // store entry from input item
        OP_COUNT,      // store row count
        OP_READ,       // issue read of entry at input address
        OP_RD_SELF,    // read links/used/counts of current hit
        OP_RD_CNT,     // read row counts of both neighbour rows
        OP_RD_NBR,     // read neighbour entries
        OP_FIX,        // write neighbour fix-ups
        OP_SELF_WR,    // write current hit links
        OP_NEXT,       // advance hit / row walk
        OP_RUN_START   // load walk counters
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic init_busy;   // row count clearing pass after reset
        logic walk_done;   // no more rows
        logic row_end;     // current row finished
        logic hit_used;    // current hit is used
    } t_sts;

    localparam logic [LINK_W-1:0] LINK_NONE = '1;

endpackage

[rtl/core/tlgc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgc_datapath
// Link table memories, row counts and the cleaning walk arithmetic.
// ----------------------------------------------------------------------------
module tlgc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlgc_pkg::t_cmd     i_cmd,
    output tlgc_pkg::t_sts     o_sts,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_hit,
    input  logic [8:0]         i_link_up,
    input  logic [8:0]         i_link_down,
    input  logic               i_used,
    input  logic [8:0]         i_hit_count,
    input  logic [8:0]         i_nrows,
    input  logic [3:0]         i_step,
    output logic [8:0]         o_rd_up,
    output logic [8:0]         o_rd_dn
);
    import tlgc_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int HW = $clog2(MAX_HITS_PER_ROW);
    localparam int AW = RW + HW;
    localparam int CW = HW + 1;
    localparam int RCW = RW + 1;
    localparam int DEPTH = MAX_ROWS * MAX_HITS_PER_ROW;

    logic [LINK_W-1:0] m_up   [DEPTH];
    logic [LINK_W-1:0] m_dn   [DEPTH];
    logic              m_used [DEPTH];
    logic [CW-1:0]     r_cnt  [MAX_ROWS];

    logic [RCW-1:0] r_row, r_nrows;
    logic [CW-1:0]  r_hit;
    logic [RCW-1:0] r_ru, r_rd;
    logic [CW-1:0]  r_cnt_self, r_cnt_up, r_cnt_dn;
    logic [LINK_W-1:0] r_up, r_dn, r_dfu, r_ufd;
    logic r_used;
    logic r_up_ok, r_dn_ok;
    logic [RW-1:0] r_clr;
    logic          r_clr_busy;

    // input address range
    logic in_rng;
    always_comb begin
        in_rng = (32'(i_row) < MAX_ROWS) && (32'(i_hit) < MAX_HITS_PER_ROW);
    end

    logic [AW-1:0] a_in, a_self, a_up, a_dn;
    assign a_in   = {i_row[RW-1:0], i_hit[HW-1:0]};
    assign a_self = {r_row[RW-1:0], r_hit[HW-1:0]};
    assign a_up   = {r_ru[RW-1:0], r_up[HW-1:0]};
    assign a_dn   = {r_rd[RW-1:0], r_dn[HW-1:0]};

    logic [CW-1:0] cnt_sat;
    assign cnt_sat = (32'(i_hit_count) > MAX_HITS_PER_ROW)
                     ? CW'(MAX_HITS_PER_ROW) : CW'(i_hit_count);

    logic [RCW-1:0] nrows_sat;
    assign nrows_sat = (32'(i_nrows) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(i_nrows);

    logic up_ok_c, dn_ok_c;
    assign up_ok_c = !r_up[LINK_W-1] && (CW'(r_up) < r_cnt_up);
    assign dn_ok_c = !r_dn[LINK_W-1] && (CW'(r_dn) < r_cnt_dn);

    logic [LINK_W-1:0] me;
    assign me = LINK_W'(r_hit);

    function automatic logic [RCW:0] r_step2();
        return (RCW+1)'({i_step, 1'b0});
    endfunction

    logic fix_up, fix_dn;
    logic [LINK_W-1:0] dfu_f, ufd_f;
    always_comb begin
        fix_up = r_up_ok && r_dn_ok && r_dfu == LINK_NONE && r_ufd == me
                 && ({1'b0, r_row} >= {r_step2()});
        fix_dn = r_up_ok && r_dn_ok && r_ufd == LINK_NONE && r_dfu == me
                 && ({1'b0, r_row} + r_step2() < {1'b0, r_nrows});
        dfu_f = fix_up ? me : r_dfu;
        ufd_f = fix_dn ? me : r_ufd;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_WRITE: begin
                if (in_rng) begin
                    m_up[a_in]   <= i_link_up;
                    m_dn[a_in]   <= i_link_down;
                    m_used[a_in] <= i_used;
                end
            end
            OP_READ: begin
                o_rd_up <= in_rng ? m_up[a_in] : LINK_NONE;
                o_rd_dn <= in_rng ? m_dn[a_in] : LINK_NONE;
            end
            OP_RUN_START: begin
                r_nrows <= nrows_sat;
                r_row   <= RCW'(i_step);
                r_hit   <= '0;
            end
            OP_RD_SELF: begin
                r_up       <= m_up[a_self];
                r_dn       <= m_dn[a_self];
                r_used     <= m_used[a_self];
                r_ru       <= r_row + RCW'(i_step);
                r_rd       <= r_row - RCW'(i_step);
            end
            OP_RD_NBR: begin
                r_up_ok <= up_ok_c;
                r_dn_ok <= dn_ok_c;
                r_dfu   <= up_ok_c ? m_dn[a_up] : LINK_NONE;
                r_ufd   <= dn_ok_c ? m_up[a_dn] : LINK_NONE;
            end
            OP_FIX: begin
                if (fix_up) m_dn[a_up] <= me;
                if (fix_dn) m_up[a_dn] <= me;
                r_dfu <= dfu_f;
                r_ufd <= ufd_f;
            end
            OP_SELF_WR: begin
                if (r_dfu != me) m_up[a_self] <= LINK_NONE;
                if (r_ufd != me) m_dn[a_self] <= LINK_NONE;
            end
            OP_NEXT: begin
                if (r_hit + 1'b1 >= r_cnt_self) begin
                    r_hit <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_hit <= r_hit + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // row count table: cleared row by row after reset, registered lookups of the current row or both neighbour rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_cnt[r_clr] <= '0;
            r_clr        <= r_clr + 1'b1;
            if (r_clr == RW'(MAX_ROWS - 1)) r_clr_busy <= 1'b0;
        end else if (i_cmd.op == OP_COUNT && 32'(i_row) < MAX_ROWS) begin
            r_cnt[i_row[RW-1:0]] <= cnt_sat;
        end
        if (i_cmd.op == OP_RD_CNT) begin
            r_cnt_up <= (r_ru < RCW'(MAX_ROWS)) ? r_cnt[r_ru[RW-1:0]] : '0;
            r_cnt_dn <= r_cnt[r_rd[RW-1:0]];
        end else begin
            r_cnt_self <= r_cnt[r_row[RW-1:0]];
        end
    end

    always_comb begin
        o_sts.init_busy = r_clr_busy;
        o_sts.walk_done = (i_step == '0) || ({1'b0, r_row} + (RCW+1)'(i_step)
                          >= {1'b0, r_nrows});
        o_sts.row_end   = (r_hit >= r_cnt_self);
        o_sts.hit_used  = r_used;
    end

endmodule

[rtl/core/tlgc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgc_ctrl
// Sequencer for load, read and cleaning-run items, with output register.
// ----------------------------------------------------------------------------
module tlgc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_mode,
    input  logic [7:0]     i_row,
    input  logic [7:0]     i_hit,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_row,
    output logic [7:0]     o_out_hit,
    output logic           o_out_done,
    output logic           o_out_from_rd,
    output tlgc_pkg::t_cmd o_cmd,
    input  tlgc_pkg::t_sts i_sts
);
    import tlgc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_START, S_CNT, S_ROW, S_SELF, S_CNTN,
        S_NBR, S_FIX, S_WR, S_NEXT, S_DONE
    } t_state;

    t_state r_state;
    logic   acc;
    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid && !i_sts.init_busy;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (t_mode'(i_mode))
                        MODE_WRITE: o_cmd.op = OP_WRITE;
                        MODE_COUNT: o_cmd.op = OP_COUNT;
                        MODE_READ:  o_cmd.op = OP_READ;
                        default:    o_cmd.op = OP_RUN_START;
                    endcase
                end
            end
            S_SELF:  o_cmd.op = OP_RD_SELF;
            S_CNTN:  o_cmd.op = OP_RD_CNT;
            S_NBR:   o_cmd.op = OP_RD_NBR;
            S_FIX:   o_cmd.op = OP_FIX;
            S_WR:    o_cmd.op = OP_SELF_WR;
            S_NEXT:  o_cmd.op = OP_NEXT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        o_out_row <= i_row;
                        o_out_hit <= i_hit;
                        if (t_mode'(i_mode) == MODE_READ) begin
                            o_out_valid   <= 1'b1;
                            o_out_done    <= 1'b0;
                            o_out_from_rd <= 1'b1;
                        end else if (t_mode'(i_mode) == MODE_RUN) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: r_state <= S_CNT;
                S_CNT:   r_state <= S_ROW;
                S_ROW: begin
                    if (i_sts.walk_done) r_state <= S_DONE;
                    else if (i_sts.row_end) r_state <= S_NEXT;
                    else r_state <= S_SELF;
                end
                S_SELF:  r_state <= S_CNTN;
                S_CNTN:  r_state <= i_sts.hit_used ? S_NEXT : S_NBR;
                S_NBR:   r_state <= S_FIX;
                S_FIX:   r_state <= S_WR;
                S_WR:    r_state <= S_NEXT;
                S_NEXT:  r_state <= S_CNT;
                S_DONE: begin
                    o_out_valid   <= 1'b1;
                    o_out_done    <= 1'b1;
                    o_out_from_rd <= 1'b0;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> o_out_valid && o_out_done) else $error("no done");
    a_read_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_mode == MODE_READ |=> o_out_valid && !o_out_done)
        else $error("read lost");

endmodule

[rtl/core/track_link_graph_cleaner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_link_graph_cleaner
// Per-row hit link table with a one-way link cleaning run.
// ----------------------------------------------------------------------------
// After reset the row count table is cleared over all MAX_ROWS rows, during
// which no transfer is accepted. Write and count items then go at one per
// cycle while no result waits to be taken. A read result is registered the
// cycle after the read is taken; the next item is taken once it is delivered.
// A run loads its walk counters and walks the rows: a used hit reads itself
// and its neighbour row counts, an unused hit also reads and fixes up its
// neighbours and writes its own links, and after the last row the done
// result is registered. A walk step accesses each link memory at most once.
// Row counts reset to zero; link entries hold garbage until written.
module track_link_graph_cleaner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[7:0] hit[15:8] link_up[24:16] link_down[33:25] used[34]
    // hit_count[43:35]
    input  logic [47:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_row[7:0] out_hit[15:8] out_link_up[24:16] out_link_down[33:25]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tuser,  // done_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tlgc_pkg::*;

    logic [8:0] r_nrows;
    logic [3:0] r_step;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrows <= '0;
            r_step  <= 4'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_NROWS) r_nrows <= pwdata[8:0];
            if (paddr == REG_STEP)  r_step  <= pwdata[3:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == REG_NROWS) prdata = 32'(r_nrows);
        if (paddr == REG_STEP)  prdata = 32'(r_step);
    end

    t_cmd cmd;
    t_sts sts;
    logic [8:0] rd_up, rd_dn;
    logic [7:0] o_row, o_hit;
    logic done, from_rd;

    tlgc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_mode(s_axis_tuser), .i_row(s_axis_tdata[7:0]),
        .i_hit(s_axis_tdata[15:8]),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_row(o_row), .o_out_hit(o_hit), .o_out_done(done),
        .o_out_from_rd(from_rd), .o_cmd(cmd), .i_sts(sts)
    );

    tlgc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_row(s_axis_tdata[7:0]), .i_hit(s_axis_tdata[15:8]),
        .i_link_up(s_axis_tdata[24:16]), .i_link_down(s_axis_tdata[33:25]),
        .i_used(s_axis_tdata[34]), .i_hit_count(s_axis_tdata[43:35]),
        .i_nrows(r_nrows), .i_step(r_step), .o_rd_up(rd_up), .o_rd_dn(rd_dn)
    );

    assign m_axis_tdata = from_rd ? {6'd0, rd_dn, rd_up, o_hit, o_row} : 40'd0;
    assign m_axis_tuser = done;

endmodule

[sim/tb_track_link_graph_cleaner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_link_graph_cleaner
// Self-checking bench for the hit link table and its cleaning run. A shadow
// table follows every accepted transfer and predicts read-back and run-done
// results; directed tests hit the link cleaning cases and the field and
// register extremes, then random tables are loaded, cleaned and read back.
// ----------------------------------------------------------------------------
module tb_track_link_graph_cleaner;
    import tlgc_pkg::*;

    localparam int NROWS  = 256;
    localparam int NHITS  = 256;
    localparam int LIMIT  = 600000;

    typedef struct {
        logic [7:0]        row;
        logic [7:0]        hit;
        logic signed [8:0] lu;
        logic signed [8:0] ld;
        logic              done;
    } t_readback;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    track_link_graph_cleaner uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_tdata),
        .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the link table
    logic signed [8:0] up_tab   [NROWS*NHITS];
    logic signed [8:0] down_tab [NROWS*NHITS];
    logic              used_tab [NROWS*NHITS];
    bit                written  [NROWS*NHITS];
    int                row_cnt  [NROWS];
    int                prefix   [NROWS];
    int                written_list[$];
    logic [8:0]        rows_reg = 0;
    logic [3:0]        step_reg = 1;

    t_readback pending[$];
    int  errors = 0;
    int  items_sent = 0;
    int  burst_left = 0;
    int  cycles = 0;
    int  rx_cnt = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL track_link_graph_cleaner");
            $finish;
        end
    end

    function automatic bit link_ok(int l, int r);
        return l >= 0 && l < row_cnt[r];
    endfunction

    task automatic clean_hit(int r, int h, int nr);
        int a, ru, rd, up, dn, dfu, ufd;
        bit up_ok, dn_ok, fix_up, fix_dn;
        a = r * NHITS + h;
        ru = r + step_reg;
        rd = r - step_reg;
        up = up_tab[a];
        dn = down_tab[a];
        up_ok = link_ok(up, ru);
        dn_ok = link_ok(dn, rd);
        dfu = up_ok ? int'(down_tab[ru * NHITS + up]) : -1;
        ufd = dn_ok ? int'(up_tab[rd * NHITS + dn]) : -1;
        fix_up = up_ok && dn_ok && dfu == -1 && ufd == h && r >= 2 * step_reg;
        fix_dn = dn_ok && up_ok && ufd == -1 && dfu == h && r + 2 * step_reg < nr;
        if (fix_up) begin
            dfu = h;
            down_tab[ru * NHITS + up] = 9'(h);
        end
        if (fix_dn) begin
            ufd = h;
            up_tab[rd * NHITS + dn] = 9'(h);
        end
        if (dfu != h) up_tab[a] = -9'sd1;
        if (ufd != h) down_tab[a] = -9'sd1;
    endtask

    task automatic clean_table();
        int nr;
        nr = rows_reg > NROWS ? NROWS : rows_reg;
        if (step_reg == 0) return;
        for (int r = step_reg; r + step_reg < nr; r++)
            for (int h = 0; h < row_cnt[r]; h++)
                if (!used_tab[r * NHITS + h]) clean_hit(r, h, nr);
    endtask

    task automatic update_table(logic [1:0] md, logic [47:0] d);
        t_mode m;
        int r, h, a, c;
        t_readback e;
        m = t_mode'(md);
        r = int'(d[7:0]);
        h = int'(d[15:8]);
        a = r * NHITS + h;
        case (m)
            MODE_WRITE: begin
                up_tab[a] = d[24:16];
                down_tab[a] = d[33:25];
                used_tab[a] = d[34];
                if (!written[a]) written_list.push_back(a);
                written[a] = 1;
                while (prefix[r] < NHITS && written[r * NHITS + prefix[r]])
                    prefix[r]++;
            end
            MODE_COUNT: begin
                c = int'(d[43:35]);
                row_cnt[r] = c > NHITS ? NHITS : c;
            end
            MODE_RUN: begin
                clean_table();
                e = '{0, 0, 0, 0, 1};
                pending.push_back(e);
            end
            default: begin
                e = '{r[7:0], h[7:0], up_tab[a], down_tab[a], 0};
                pending.push_back(e);
            end
        endcase
    endtask

    task automatic send_item(t_mode m, int r, int h, int lu, int ld, bit u, int c);
        logic [8:0] lu9, ld9, c9;
        int gap;
        lu9 = 9'(lu);
        ld9 = 9'(ld);
        c9 = 9'(c);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser <= m;
        s_tdata <= {4'd0, c9, u, ld9, lu9, h[7:0], r[7:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        update_table(s_tuser, s_tdata);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [CFG_AW-1:0] ad, logic [31:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ad;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (ad == REG_NROWS) rows_reg = v[8:0];
        else step_reg = v[3:0];
    endtask

    task automatic configure(int nr, int st);
        wait_idle();
        reg_write(REG_NROWS, 32'(nr));
        reg_write(REG_STEP, 32'(st));
    endtask

    task automatic read_random(int n);
        int a;
        for (int i = 0; i < n && written_list.size() > 0; i++) begin
            a = written_list[$urandom_range(0, written_list.size() - 1)];
            send_item(MODE_READ, a / NHITS, a % NHITS, 0, 0, 0, 0);
        end
    endtask

    // checks every delivered result against the oldest prediction
    always @(posedge i_clk) begin
        t_readback e;
        if (m_axis_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h user %b", $realtime, m_axis_tdata,
                         m_axis_tuser);
                errors++;
            end else begin
                e = pending.pop_front();
                if (m_axis_tdata[7:0] !== e.row || m_axis_tdata[15:8] !== e.hit ||
                    m_axis_tdata[24:16] !== e.lu || m_axis_tdata[33:25] !== e.ld ||
                    m_axis_tuser !== e.done) begin
                    $display("%0t: expected row %0d hit %0d up %0d down %0d done %b",
                             $realtime, e.row, e.hit, e.lu, e.ld, e.done);
                    $display("%0t: actual   row %0d hit %0d up %0d down %0d done %b",
                             $realtime, m_axis_tdata[7:0], m_axis_tdata[15:8],
                             $signed(m_axis_tdata[24:16]), $signed(m_axis_tdata[33:25]),
                             m_axis_tuser);
                    errors++;
                end
            end
        end
        if (rx_cnt == 0) begin
            rx_cnt <= $urandom_range(1, 12);
            m_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            rx_cnt <= rx_cnt - 1;
        end
    end

    // up/down fix-ups, dangling link, used hit, one-way clears
    task automatic test_cleaning_cases();
        configure(6, 1);
        send_item(MODE_WRITE, 0, 0, 0, -1, 0, 0);
        send_item(MODE_WRITE, 1, 0, 0, 0, 0, 0);
        send_item(MODE_WRITE, 1, 1, 5, 3, 1, 0);
        send_item(MODE_WRITE, 2, 0, -1, 0, 0, 0);
        send_item(MODE_WRITE, 2, 1, 7, -1, 0, 0);
        send_item(MODE_WRITE, 3, 0, 0, 0, 0, 0);
        send_item(MODE_WRITE, 4, 0, 0, 0, 0, 0);
        send_item(MODE_WRITE, 5, 0, -1, 0, 0, 0);
        send_item(MODE_COUNT, 0, 0, 0, 0, 0, 1);
        send_item(MODE_COUNT, 1, 0, 0, 0, 0, 2);
        send_item(MODE_COUNT, 2, 0, 0, 0, 0, 2);
        send_item(MODE_COUNT, 3, 0, 0, 0, 0, 1);
        send_item(MODE_COUNT, 4, 0, 0, 0, 0, 1);
        send_item(MODE_COUNT, 5, 0, 0, 0, 0, 1);
        send_item(MODE_RUN, 0, 0, 0, 0, 0, 0);
        for (int r = 0; r < 6; r++) send_item(MODE_READ, r, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 1, 1, 0, 0, 0, 0);
        send_item(MODE_READ, 2, 1, 0, 0, 0, 0);
    endtask

    task automatic test_field_extremes();
        send_item(MODE_WRITE, 255, 255, 255, -1, 1, 0);
        send_item(MODE_WRITE, 254, 170, -1, 255, 0, 0);
        send_item(MODE_WRITE, 253, 85, 170, 85, 0, 0);
        send_item(MODE_READ, 255, 255, 0, 0, 0, 0);
        send_item(MODE_READ, 254, 170, 0, 0, 0, 0);
        send_item(MODE_READ, 253, 85, 0, 0, 0, 0);
        send_item(MODE_COUNT, 255, 0, 0, 0, 0, 256);
        send_item(MODE_COUNT, 255, 0, 0, 0, 0, 0);
    endtask

    task automatic test_register_extremes();
        configure(300, 1);
        send_item(MODE_RUN, 0, 0, 0, 0, 0, 0);
        configure(256, 15);
        send_item(MODE_RUN, 0, 0, 0, 0, 0, 0);
        configure(6, 0);
        send_item(MODE_RUN, 0, 0, 0, 0, 0, 0);
        configure(0, 2);
        send_item(MODE_RUN, 0, 0, 0, 0, 0, 0);
        read_random(4);
    endtask

    // random tables: load, count, clean, read back
    task automatic test_random_tables();
        int nr, st, k, lu, ld;
        int cnt[16];
        while (items_sent < 390) begin
            nr = $urandom_range(3, 14);
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 1;
            configure(nr, st);
            for (int r = 0; r < nr; r++) cnt[r] = $urandom_range(0, 4);
            for (int r = 0; r < nr; r++)
                for (int h = 0; h < cnt[r]; h++) begin
                    k = $urandom_range(0, 9);
                    lu = (k < 2) ? -1 : (k == 9) ? $urandom_range(0, 255) : $urandom_range(0, 4);
                    k = $urandom_range(0, 9);
                    ld = (k < 2) ? -1 : (k == 9) ? $urandom_range(0, 255) : $urandom_range(0, 4);
                    send_item(MODE_WRITE, r, h, lu, ld, $urandom_range(0, 7) == 0, 0);
                end
            for (int i = $urandom_range(0, 2); i > 0; i--)
                send_item(MODE_WRITE, $urandom_range(16, 255), $urandom_range(0, 255),
                          $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                          $urandom_range(0, 1), 0);
            for (int r = 0; r < nr; r++)
                send_item(MODE_COUNT, r, $urandom_range(0, 255), 0, 0, 0,
                          cnt[r] < prefix[r] ? cnt[r] : prefix[r]);
            read_random($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0) wait_idle();
            send_item(MODE_RUN, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, 0, 0);
            for (int r = 0; r < nr; r++)
                for (int h = 0; h < cnt[r]; h++)
                    if ($urandom_range(0, 1) == 0) send_item(MODE_READ, r, h, 0, 0, 0, 0);
        end
    endtask

    initial begin
        for (int r = 0; r < NROWS; r++) begin
            row_cnt[r] = 0;
            prefix[r] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_cleaning_cases();
        test_field_extremes();
        test_register_extremes();
        test_random_tables();
        wait_idle();
        if (errors == 0) begin
            $display("PASS track_link_graph_cleaner");
        end else begin
            $display("FAIL track_link_graph_cleaner");
        end
        $finish;
    end

endmodule
